// ----- design/cbz_pkg.sv -----
`timescale 1ns / 1ps

package cbz_pkg;

  // Configuration register map: one register per control coordinate.
  localparam int unsigned CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CTRL0_X = 3'd0,
    REG_CTRL0_Y = 3'd1,
    REG_CTRL1_X = 3'd2,
    REG_CTRL1_Y = 3'd3,
    REG_CTRL2_X = 3'd4,
    REG_CTRL2_Y = 3'd5,
    REG_CTRL3_X = 3'd6,
    REG_CTRL3_Y = 3'd7
  } cbz_reg_t;

  // Stages of one blend unit and of the whole datapath (input stage plus
  // three de Casteljau levels).
  localparam int unsigned BLEND_LAT = 3;
  localparam int unsigned PIPE_LAT  = 1 + 3 * BLEND_LAT;

endpackage

// ----- design/cbz_blend.sv -----
`timescale 1ns / 1ps

// Pipelined linear blend a + round((b - a) * t / 2^F), rounding half away
// from zero. The result is registered.
module cbz_blend #(
  parameter int unsigned W = 32,
  parameter int unsigned F = 16
) (
  input  logic                clk,
  input  logic signed [W-1:0] a,
  input  logic signed [W-1:0] b,
  input  logic        [F:0]   t,
  output logic signed [W-1:0] res
);

  localparam logic [W+F:0] HALF = (W+F+1)'(1) << (F - 1);

  logic        [W:0]     diff;
  logic        [W:0]     mag;
  logic        [W+F:0]   prod;
  logic        [W-1:0]   rnd;
  logic        [W:0]     sum;

  logic signed [W-1:0]   a1_r, a2_r;
  logic                  neg1_r, neg2_r;
  logic        [W-1:0]   m1_r;
  logic        [F:0]     t1_r;
  logic        [W+F:0]   prod2_r;
  logic signed [W-1:0]   res_r;

  // Stage 1: signed difference split into sign and magnitude.
  always_comb begin
    diff = {b[W-1], b} - {a[W-1], a};
    mag  = diff[W] ? (~diff + 1'b1) : diff;
  end

  always_ff @(posedge clk) begin
    a1_r   <= a;
    neg1_r <= diff[W];
    m1_r   <= mag[W-1:0];
    t1_r   <= t;
  end

  // Stage 2: magnitude times t, with the rounding half folded in.
  assign prod = (W+F+1)'(m1_r) * (W+F+1)'(t1_r) + HALF;

  always_ff @(posedge clk) begin
    a2_r    <= a1_r;
    neg2_r  <= neg1_r;
    prod2_r <= prod;
  end

  // Stage 3: apply the rounded step with its sign. Since t never exceeds
  // one, the step is at most the magnitude and the result stays in range.
  always_comb begin
    rnd = prod2_r[W+F-1:F];
    sum = neg2_r ? ({a2_r[W-1], a2_r} - {1'b0, rnd})
                 : ({a2_r[W-1], a2_r} + {1'b0, rnd});
  end

  always_ff @(posedge clk) begin
    res_r <= sum[W-1:0];
  end

  assign res = res_r;

endmodule

// ----- design/cubic_bezier_point_and_tangent.sv -----
`timescale 1ns / 1ps

// Channel   Ports                                          Direction
// input     start, busy, in_curve_param                    in (busy out)
// result    out_valid, out_point_x/y, out_tangent_x/y      out
// config    cfg_we, cfg_index, cfg_wdata                   in
//
// A new word is taken every clock; busy is always low.
// Each result passes ten register stages: the input register, loaded at the
// edge that takes the word, then three de Casteljau levels of three-stage blend
// units. out_valid therefore rises as the point and tangent leave the last stage.
// out_valid is high for one clock per result; the receiver cannot stall.
// Reset is synchronous and clears the valid bits and control points.
module cubic_bezier_point_and_tangent #(
  parameter int unsigned COORD_WIDTH     = 32,
  parameter int unsigned PARAM_FRAC_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic        [PARAM_FRAC_BITS:0]  in_curve_param,
  output logic                             out_valid,
  output logic signed [COORD_WIDTH-1:0]    out_point_x,
  output logic signed [COORD_WIDTH-1:0]    out_point_y,
  output logic signed [COORD_WIDTH-1:0]    out_tangent_x,
  output logic signed [COORD_WIDTH-1:0]    out_tangent_y,
  input  logic                             cfg_we,
  input  logic [cbz_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic        [COORD_WIDTH-1:0]    cfg_wdata
);

  import cbz_pkg::*;

  localparam int unsigned W = COORD_WIDTH;
  localparam int unsigned F = PARAM_FRAC_BITS;
  localparam logic [F:0]  T_ONE = {1'b1, {F{1'b0}}};
  localparam int unsigned T_LAT = 2 * BLEND_LAT + 1;

  logic signed [W-1:0] ctrl_r [2][4];
  logic [PIPE_LAT-1:0] vld_r;
  logic [F:0]          tq_r [T_LAT];
  logic [F:0]          t_clamp;
  logic signed [W-1:0] pt_w  [2];
  logic signed [W-1:0] tan_w [2];

  assign busy = 1'b0;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int a = 0; a < 2; a++) begin
        for (int k = 0; k < 4; k++) begin
          ctrl_r[a][k] <= '0;
        end
      end
    end else if (cfg_we) begin
      unique case (cbz_reg_t'(cfg_index))
        REG_CTRL0_X: ctrl_r[0][0] <= cfg_wdata;
        REG_CTRL0_Y: ctrl_r[1][0] <= cfg_wdata;
        REG_CTRL1_X: ctrl_r[0][1] <= cfg_wdata;
        REG_CTRL1_Y: ctrl_r[1][1] <= cfg_wdata;
        REG_CTRL2_X: ctrl_r[0][2] <= cfg_wdata;
        REG_CTRL2_Y: ctrl_r[1][2] <= cfg_wdata;
        REG_CTRL3_X: ctrl_r[0][3] <= cfg_wdata;
        REG_CTRL3_Y: ctrl_r[1][3] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // A parameter above one is taken as exactly one.
  assign t_clamp = (in_curve_param > T_ONE) ? T_ONE : in_curve_param;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[PIPE_LAT-2:0], start & ~busy};
    end
  end

  always_ff @(posedge clk) begin
    tq_r[0] <= t_clamp;
    for (int i = 1; i < T_LAT; i++) begin
      tq_r[i] <= tq_r[i-1];
    end
  end

  for (genvar ax = 0; ax < 2; ax++) begin : g_axis
    logic signed [W-1:0] q [3];
    logic signed [W-1:0] r [2];
    logic        [W:0]   diff_r;
    logic        [W+2:0] tri_r;
    logic signed [W-1:0] tan_r;
    logic        [3:0]   top_bits;

    for (genvar k = 0; k < 3; k++) begin : g_lvl1
      cbz_blend #(.W(W), .F(F)) u_blend (
        .clk (clk),
        .a   (ctrl_r[ax][k]),
        .b   (ctrl_r[ax][k+1]),
        .t   (tq_r[0]),
        .res (q[k])
      );
    end

    for (genvar k = 0; k < 2; k++) begin : g_lvl2
      cbz_blend #(.W(W), .F(F)) u_blend (
        .clk (clk),
        .a   (q[k]),
        .b   (q[k+1]),
        .t   (tq_r[BLEND_LAT]),
        .res (r[k])
      );
    end

    cbz_blend #(.W(W), .F(F)) u_point (
      .clk (clk),
      .a   (r[0]),
      .b   (r[1]),
      .t   (tq_r[2*BLEND_LAT]),
      .res (pt_w[ax])
    );

    // Tangent 3*(r1 - r0), saturated; three stages to line up with the point.
    assign top_bits = tri_r[W+2:W-1];

    always_ff @(posedge clk) begin
      diff_r <= {r[1][W-1], r[1]} - {r[0][W-1], r[0]};
      tri_r  <= {{2{diff_r[W]}}, diff_r} + {diff_r[W], diff_r, 1'b0};
      if ((&top_bits) || !(|top_bits)) begin
        tan_r <= tri_r[W-1:0];
      end else if (tri_r[W+2]) begin
        tan_r <= {1'b1, {(W-1){1'b0}}};
      end else begin
        tan_r <= {1'b0, {(W-1){1'b1}}};
      end
    end

    assign tan_w[ax] = tan_r;
  end

  assign out_valid     = vld_r[PIPE_LAT-1];
  assign out_point_x   = pt_w[0];
  assign out_point_y   = pt_w[1];
  assign out_tangent_x = tan_w[0];
  assign out_tangent_y = tan_w[1];

  // Every result traces back to a word taken earlier at the input.
  a_out_has_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && rst_n, PIPE_LAT))
    else $error("result without a matching input word");

  // The clamped parameter never exceeds one.
  a_t_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[0] |-> (tq_r[0] <= T_ONE))
    else $error("parameter above one entered the datapath");

  // At t = 0 the curve point is the first control point.
  a_point_start: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && $past(vld_r[0] && (tq_r[0] == '0), PIPE_LAT - 1))
      |-> (out_point_x == ctrl_r[0][0]) && (out_point_y == ctrl_r[1][0]))
    else $error("point at t = 0 differs from the first control point");

  // At t = 1 the curve point is the last control point.
  a_point_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && $past(vld_r[0] && (tq_r[0] == T_ONE), PIPE_LAT - 1))
      |-> (out_point_x == ctrl_r[0][3]) && (out_point_y == ctrl_r[1][3]))
    else $error("point at t = 1 differs from the last control point");

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import cbz_pkg::*;

  localparam int unsigned COORD_W = 32;
  localparam int unsigned FRAC = 16;
  localparam longint ONE = longint'(1) << FRAC;
  localparam longint HALF = longint'(1) << (FRAC - 1);
  localparam longint COORD_MAX = (longint'(1) << (COORD_W - 1)) - 1;
  localparam longint COORD_MIN = -COORD_MAX - 1;
  localparam int unsigned RANDOM_PHASES = 6;
  localparam int unsigned WORDS_PER_PHASE = 300;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [FRAC:0] param_t;
  typedef coord_t curve_t [8];
  typedef param_t param_list_t [$];

  typedef struct packed {
    coord_t point_x;
    coord_t point_y;
    coord_t tangent_x;
    coord_t tangent_y;
  } sample_t;

  typedef enum {SPREAD_FULL, SPREAD_LOCAL, SPREAD_EDGE} spread_t;

  localparam param_t PARAM_ONE = param_t'(ONE);
  localparam param_t PARAM_TOP = '1;
  localparam coord_t C_MAX = coord_t'(COORD_MAX);
  localparam coord_t C_MIN = coord_t'(COORD_MIN);

  // Holds its own copy of the control points and the samples still owed.
  class curve_scoreboard;
    coord_t ctrl [8];
    sample_t expected_q [$];
    int unsigned fails;

    function new();
      foreach (ctrl[i]) ctrl[i] = '0;
      fails = 0;
    endfunction

    function void load_reg(int unsigned idx, coord_t value);
      ctrl[idx] = value;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    // a + (b - a) * t, with the product rounded half away from zero.
    function longint mix(longint a, longint b, longint t);
      longint diff;
      longint mag;
      longint step;
      diff = b - a;
      mag = (diff < 0) ? -diff : diff;
      step = (mag * t + HALF) >>> FRAC;
      return (diff < 0) ? a - step : a + step;
    endfunction

    function void trace_axis(coord_t c0, coord_t c1, coord_t c2, coord_t c3, longint t,
                             output coord_t pt, output coord_t slope);
      longint q0, q1, q2, r0, r1, d;
      q0 = mix(c0, c1, t);
      q1 = mix(c1, c2, t);
      q2 = mix(c2, c3, t);
      r0 = mix(q0, q1, t);
      r1 = mix(q1, q2, t);
      d = 3 * (r1 - r0);
      if (d > COORD_MAX) d = COORD_MAX;
      else if (d < COORD_MIN) d = COORD_MIN;
      pt = coord_t'(mix(r0, r1, t));
      slope = coord_t'(d);
    endfunction

    function void note_word(param_t param);
      longint t;
      sample_t s;
      t = longint'(param);
      // Anything past 1.0 evaluates at the curve end.
      if (t > ONE) t = ONE;
      trace_axis(ctrl[REG_CTRL0_X], ctrl[REG_CTRL1_X], ctrl[REG_CTRL2_X], ctrl[REG_CTRL3_X],
                 t, s.point_x, s.tangent_x);
      trace_axis(ctrl[REG_CTRL0_Y], ctrl[REG_CTRL1_Y], ctrl[REG_CTRL2_Y], ctrl[REG_CTRL3_Y],
                 t, s.point_y, s.tangent_y);
      expected_q = {expected_q, s};
    endfunction

    function void compare(string name, coord_t want, coord_t got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        fails++;
      end
    endfunction

    function void check_result(sample_t got);
      sample_t want;
      if (expected_q.size() == 0) begin
        $error("result word with no parameter outstanding");
        fails++;
        return;
      end
      want = expected_q.pop_front();
      compare("point_x", want.point_x, got.point_x);
      compare("point_y", want.point_y, got.point_y);
      compare("tangent_x", want.tangent_x, got.tangent_x);
      compare("tangent_y", want.tangent_y, got.tangent_y);
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  param_t in_curve_param;
  logic out_valid;
  coord_t out_point_x;
  coord_t out_point_y;
  coord_t out_tangent_x;
  coord_t out_tangent_y;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [COORD_W-1:0] cfg_wdata;

  curve_scoreboard sb = new();

  cubic_bezier_point_and_tangent #(
    .COORD_WIDTH(COORD_W),
    .PARAM_FRAC_BITS(FRAC)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_curve_param(in_curve_param),
    .out_valid(out_valid),
    .out_point_x(out_point_x),
    .out_point_y(out_point_y),
    .out_tangent_x(out_tangent_x),
    .out_tangent_y(out_tangent_y),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #5000000;
    $display("FAILURE");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) sb.load_reg(cfg_index, cfg_wdata);
      if (start && !busy) sb.note_word(in_curve_param);
      if (out_valid) sb.check_result({out_point_x, out_point_y, out_tangent_x, out_tangent_y});
    end
  end

  // Busy is stable at the falling edge, so the word goes in at the next rising edge.
  task automatic send_word(param_t t);
    start <= 1'b1;
    in_curve_param <= t;
    @(negedge clk);
    while (busy) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic idle_for(int unsigned n);
    if (n != 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    @(negedge clk);
    while (sb.pending() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic load_curve(curve_t c);
    drain();
    for (int i = 0; i < 8; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= cbz_reg_t'(i);
      cfg_wdata <= c[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic run_params(param_list_t list);
    foreach (list[i]) send_word(list[i]);
  endtask

  function automatic curve_t make_curve(coord_t x0, coord_t y0, coord_t x1, coord_t y1,
                                        coord_t x2, coord_t y2, coord_t x3, coord_t y3);
    curve_t c;
    c[REG_CTRL0_X] = x0;
    c[REG_CTRL0_Y] = y0;
    c[REG_CTRL1_X] = x1;
    c[REG_CTRL1_Y] = y1;
    c[REG_CTRL2_X] = x2;
    c[REG_CTRL2_Y] = y2;
    c[REG_CTRL3_X] = x3;
    c[REG_CTRL3_Y] = y3;
    return c;
  endfunction

  function automatic param_t random_param();
    case ($urandom_range(0, 15))
      0: return '0;
      1: return PARAM_ONE;
      2: return param_t'($urandom_range(PARAM_TOP, PARAM_ONE + 1));
      default: return param_t'($urandom_range(0, PARAM_ONE));
    endcase
  endfunction

  function automatic coord_t random_coord(spread_t spread);
    case (spread)
      SPREAD_FULL: return coord_t'($urandom());
      SPREAD_LOCAL: return coord_t'($urandom_range(0, 1 << 22)) - coord_t'(1 << 21);
      default: begin
        case ($urandom_range(0, 4))
          0: return C_MIN;
          1: return C_MAX;
          2: return '0;
          3: return '1;
          default: return coord_t'(1);
        endcase
      end
    endcase
  endfunction

  initial begin
    curve_t c;
    param_list_t picks;
    int unsigned sent;
    int unsigned burst;
    spread_t spread;

    rst_n <= 1'b0;
    start <= 1'b0;
    in_curve_param <= '0;
    cfg_we <= 1'b0;
    cfg_index <= REG_CTRL0_X;
    cfg_wdata <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // All control points still at zero after reset.
    picks = '{param_t'(0), PARAM_ONE, PARAM_TOP};
    run_params(picks);

    // Odd coordinates so that t = 0.5 lands exactly on a rounding half.
    c = make_curve(3, -5, 65537, 131073, -196607, -131071, 262145, 32769);
    load_curve(c);
    picks = '{param_t'(0), param_t'(1), param_t'(32768), param_t'(65535), PARAM_ONE,
              PARAM_ONE + 1, param_t'(98304), PARAM_TOP, param_t'(16384), param_t'(43691)};
    run_params(picks);

    // Control points swinging between the extremes drive the tangent into saturation.
    c = make_curve(C_MIN, C_MAX, C_MAX, C_MIN, C_MIN, C_MAX, C_MAX, C_MIN);
    load_curve(c);
    picks = '{param_t'(0), param_t'(32768), PARAM_ONE, param_t'(21845)};
    run_params(picks);

    c = make_curve(C_MAX, C_MIN, C_MAX, C_MIN, C_MAX, C_MIN, C_MAX, C_MIN);
    load_curve(c);
    picks = '{param_t'(0), PARAM_ONE, param_t'(12345)};
    run_params(picks);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      foreach (c[i]) begin
        spread = (p < 3) ? spread_t'(p) : spread_t'($urandom_range(0, 2));
        c[i] = random_coord(spread);
      end
      load_curve(c);
      sent = 0;
      while (sent < WORDS_PER_PHASE) begin
        burst = $urandom_range(1, 40);
        for (int k = 0; k < burst && sent < WORDS_PER_PHASE; k++) begin
          send_word(random_param());
          sent++;
        end
        if ($urandom_range(0, 29) == 0) drain();
        else if ($urandom_range(0, 2) != 0) idle_for($urandom_range(1, 8));
      end
    end

    drain();
    repeat (PIPE_LAT + 4) @(posedge clk);
    if (sb.fails == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
design/cbz_pkg.sv
design/cbz_blend.sv
design/cubic_bezier_point_and_tangent.sv
bench/testbench.sv
